FILE: hw/rtl/spcc_pkg.sv
package spcc_pkg;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_ECHO = 10'b00_0000_0010,
      ST_BS1  = 10'b00_0000_0100,
      ST_BS2  = 10'b00_0000_1000,
      ST_BS3  = 10'b00_0001_0000,
      ST_SCAN = 10'b00_0010_0000,
      ST_MUL  = 10'b00_0100_0000,
      ST_DIV  = 10'b00_1000_0000,
      ST_CMP  = 10'b01_0000_0000,
      ST_DONE = 10'b10_0000_0000
   } state_type;

   typedef enum logic [3:0] {
      PH_WORD  = 4'b0001,
      PH_SKIP  = 4'b0010,
      PH_DIGIT = 4'b0100,
      PH_STOP  = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      STAT_NONE    = 3'd0,
      STAT_HELP    = 3'd1,
      STAT_PERIOD  = 3'd2,
      STAT_DUTY    = 3'd3,
      STAT_INVALID = 3'd4
   } status_type;

   localparam logic [7:0] CHAR_BS    = 8'd8;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_QUERY = 8'h3f;

   localparam logic [15:0] PERIOD_RESET  = 16'd858;
   localparam logic [15:0] COMPARE_RESET = 16'd72;

   // x / 100 for x below 100 * 65536, as (x * RECIP_100) >> RECIP_SHIFT
   localparam logic [31:0] DUTY_SAT_LIMIT = 32'd6553600;
   localparam logic [23:0] RECIP_100      = 24'd10737419;
   localparam int          RECIP_SHIFT    = 30;

   localparam int PERIOD_WORD_LEN = 6;
   localparam int DUTY_WORD_LEN   = 4;

   function automatic logic [7:0] period_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h70;
         3'd1:    ch = 8'h65;
         3'd2:    ch = 8'h72;
         3'd3:    ch = 8'h69;
         3'd4:    ch = 8'h6f;
         3'd5:    ch = 8'h64;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] duty_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = 8'h64;
         2'd1:    ch = 8'h75;
         2'd2:    ch = 8'h74;
         2'd3:    ch = 8'h79;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: hw/rtl/spcc_ram.sv
module spcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/serial_pwm_command_console_unit.sv
// serial console line editor and pwm command parser
//
// req channel: one received console byte per beat in req_tdata.
// rsp channel: echo byte, current period and compare in rsp_tdata, line status
// in rsp_tuser, rsp_tlast on the final beat caused by one input byte.
// a byte of 32 or above is written to the line ram while there is room and
// echoed from the echo state; a backspace on a non-empty line gives three
// beats (backspace, space, backspace); carriage return walks the line ram one
// entry per cycle, then emits the newline beat with its status, after the
// duty multiply and scaling by 1/100 for a duty command. ignored bytes leave
// the block idle. one byte is handled at a time: req_tready is high only
// while the block is idle, and a new byte can be taken while the last beat
// still waits in the output register.
// a stalled rsp_tready holds the output register and the block waits in its
// current emit step. reset empties the line and loads period 858 and
// compare 72; the line ram is not cleared, only entries below the line
// length are ever read.
module serial_pwm_command_console_unit #(
   parameter int LINE_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // echo_byte, period_value, compare_value
   output logic [3:0]  rsp_tuser,   // line_done, status
   output logic        rsp_tlast
);

   localparam int AW = $clog2(LINE_LEN);
   localparam int LW = $clog2(LINE_LEN + 1);

   spcc_pkg::state_type  state_ff, state_in;
   spcc_pkg::phase_type  phase_ff, phase_in;
   spcc_pkg::status_type status_ff, status_in;

   logic [LW-1:0] line_len_ff, line_len_in;
   logic [LW-1:0] scan_idx_ff, scan_idx_in;
   logic [LW-1:0] word_idx_ff, word_idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          p_ok_ff, p_ok_in;
   logic          d_ok_ff, d_ok_in;
   logic          first_q_ff, first_q_in;
   logic          neg_ff, neg_in;
   logic [16:0]   acc_ff, acc_in;
   logic [15:0]   period_ff, period_in;
   logic [15:0]   compare_ff, compare_in;
   logic [15:0]   num_ff, num_in;
   logic [31:0]   prod_ff, prod_in;
   logic [46:0]   scaled_ff, scaled_in;
   logic          sat_ff, sat_in;
   logic [7:0]    byte_ff, byte_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_echo_ff, rsp_echo_in;
   logic          rsp_done_ff, rsp_done_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_period_ff, rsp_period_in;
   logic [15:0]   rsp_compare_ff, rsp_compare_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic          req_fire;
   logic          out_free;
   logic          is_digit;
   logic [19:0]   acc_wide;
   logic [15:0]   num_val;
   logic          has_room;

   spcc_ram #(
      .WIDTH (8),
      .DEPTH (LINE_LEN)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_tdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == spcc_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign has_room   = line_len_ff < LW'(LINE_LEN);
   assign is_digit   = (ram_rdata >= spcc_pkg::CHAR_ZERO) && (ram_rdata <= spcc_pkg::CHAR_NINE);
   assign acc_wide   = 20'(acc_ff) * 20'd10 + 20'(ram_rdata[3:0]);
   assign num_val    = neg_ff ? 16'd0 : (acc_ff[16] ? 16'hffff : acc_ff[15:0]);
   assign ram_waddr  = line_len_ff[AW-1:0];
   assign ram_raddr  = scan_idx_ff[AW-1:0];

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      status_in      = status_ff;
      line_len_in    = line_len_ff;
      scan_idx_in    = scan_idx_ff;
      word_idx_in    = word_idx_ff;
      rd_vld_in      = 1'b0;
      p_ok_in        = p_ok_ff;
      d_ok_in        = d_ok_ff;
      first_q_in     = first_q_ff;
      neg_in         = neg_ff;
      acc_in         = acc_ff;
      period_in      = period_ff;
      compare_in     = compare_ff;
      num_in         = num_ff;
      prod_in        = prod_ff;
      scaled_in      = scaled_ff;
      sat_in         = sat_ff;
      byte_in        = byte_ff;
      ram_we         = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_echo_in    = rsp_echo_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_period_in  = rsp_period_ff;
      rsp_compare_in = rsp_compare_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         spcc_pkg::ST_IDLE: begin
            if (req_fire) begin
               byte_in = req_tdata;
               case (req_tdata) inside
                  spcc_pkg::CHAR_CR: begin
                     scan_idx_in = '0;
                     word_idx_in = '0;
                     phase_in    = spcc_pkg::PH_WORD;
                     p_ok_in     = 1'b1;
                     d_ok_in     = 1'b1;
                     first_q_in  = 1'b0;
                     neg_in      = 1'b0;
                     acc_in      = '0;
                     state_in    = spcc_pkg::ST_SCAN;
                  end
                  spcc_pkg::CHAR_BS: begin
                     if (line_len_ff != '0) begin
                        line_len_in = line_len_ff - LW'(1);
                        state_in    = spcc_pkg::ST_BS1;
                     end
                  end
                  [8'd32:8'd255]: begin
                     if (has_room) begin
                        ram_we      = 1'b1;
                        line_len_in = line_len_ff + LW'(1);
                        state_in    = spcc_pkg::ST_ECHO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         spcc_pkg::ST_ECHO, spcc_pkg::ST_BS1, spcc_pkg::ST_BS2, spcc_pkg::ST_BS3: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_done_in    = 1'b0;
               rsp_status_in  = spcc_pkg::STAT_NONE;
               rsp_period_in  = period_ff;
               rsp_compare_in = compare_ff;
               rsp_last_in    = 1'b1;
               rsp_echo_in    = spcc_pkg::CHAR_BS;
               state_in       = spcc_pkg::ST_IDLE;
               if (state_ff == spcc_pkg::ST_ECHO) begin
                  rsp_echo_in = byte_ff;
               end else if (state_ff == spcc_pkg::ST_BS1) begin
                  rsp_last_in = 1'b0;
                  state_in    = spcc_pkg::ST_BS2;
               end else if (state_ff == spcc_pkg::ST_BS2) begin
                  rsp_echo_in = spcc_pkg::CHAR_SPACE;
                  rsp_last_in = 1'b0;
                  state_in    = spcc_pkg::ST_BS3;
               end
            end
         end
         spcc_pkg::ST_SCAN: begin
            if (scan_idx_ff < line_len_ff) begin
               rd_vld_in   = 1'b1;
               scan_idx_in = scan_idx_ff + LW'(1);
            end
            if (rd_vld_ff) begin
               case (phase_ff)
                  spcc_pkg::PH_WORD: begin
                     if (ram_rdata == spcc_pkg::CHAR_SPACE) begin
                        phase_in = spcc_pkg::PH_SKIP;
                     end else begin
                        if (word_idx_ff == '0 && ram_rdata == spcc_pkg::CHAR_QUERY) begin
                           first_q_in = 1'b1;
                        end
                        p_ok_in = p_ok_ff && (word_idx_ff < LW'(spcc_pkg::PERIOD_WORD_LEN))
                                  && (ram_rdata == spcc_pkg::period_char(word_idx_ff[2:0]));
                        d_ok_in = d_ok_ff && (word_idx_ff < LW'(spcc_pkg::DUTY_WORD_LEN))
                                  && (ram_rdata == spcc_pkg::duty_char(word_idx_ff[1:0]));
                        word_idx_in = word_idx_ff + LW'(1);
                     end
                  end
                  spcc_pkg::PH_SKIP: begin
                     if (ram_rdata == spcc_pkg::CHAR_SPACE) begin
                        phase_in = spcc_pkg::PH_SKIP;
                     end else if (ram_rdata == spcc_pkg::CHAR_PLUS) begin
                        phase_in = spcc_pkg::PH_DIGIT;
                     end else if (ram_rdata == spcc_pkg::CHAR_MINUS) begin
                        neg_in   = 1'b1;
                        phase_in = spcc_pkg::PH_DIGIT;
                     end else if (is_digit) begin
                        acc_in   = {13'd0, ram_rdata[3:0]};
                        phase_in = spcc_pkg::PH_DIGIT;
                     end else begin
                        phase_in = spcc_pkg::PH_STOP;
                     end
                  end
                  spcc_pkg::PH_DIGIT: begin
                     if (is_digit) begin
                        acc_in = (acc_wide > 20'd65535) ? 17'h10000 : acc_wide[16:0];
                     end else begin
                        phase_in = spcc_pkg::PH_STOP;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (!(scan_idx_ff < line_len_ff)) begin
               state_in = spcc_pkg::ST_DONE;
               if (phase_ff == spcc_pkg::PH_WORD) begin
                  status_in = (line_len_ff == LW'(1) && first_q_ff) ?
                              spcc_pkg::STAT_HELP : spcc_pkg::STAT_NONE;
               end else if (p_ok_ff && word_idx_ff == LW'(spcc_pkg::PERIOD_WORD_LEN)) begin
                  status_in = spcc_pkg::STAT_PERIOD;
                  period_in = num_val;
               end else if (d_ok_ff && word_idx_ff == LW'(spcc_pkg::DUTY_WORD_LEN)) begin
                  status_in = spcc_pkg::STAT_DUTY;
                  num_in    = num_val;
                  state_in  = spcc_pkg::ST_MUL;
               end else begin
                  status_in = spcc_pkg::STAT_INVALID;
               end
            end
         end
         spcc_pkg::ST_MUL: begin
            prod_in  = 32'(num_ff) * 32'(period_ff);
            state_in = spcc_pkg::ST_DIV;
         end
         spcc_pkg::ST_DIV: begin
            sat_in    = prod_ff >= spcc_pkg::DUTY_SAT_LIMIT;
            scaled_in = 47'(prod_ff[22:0]) * 47'(spcc_pkg::RECIP_100);
            state_in  = spcc_pkg::ST_CMP;
         end
         spcc_pkg::ST_CMP: begin
            compare_in = sat_ff ? 16'hffff
                                : scaled_ff[spcc_pkg::RECIP_SHIFT +: 16];
            state_in   = spcc_pkg::ST_DONE;
         end
         spcc_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_echo_in    = spcc_pkg::CHAR_LF;
               rsp_done_in    = 1'b1;
               rsp_status_in  = status_ff;
               rsp_period_in  = period_ff;
               rsp_compare_in = compare_ff;
               rsp_last_in    = 1'b1;
               line_len_in    = '0;
               state_in       = spcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spcc_pkg::ST_IDLE;
         line_len_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         period_ff    <= spcc_pkg::PERIOD_RESET;
         compare_ff   <= spcc_pkg::COMPARE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_len_ff  <= line_len_in;
         rd_vld_ff    <= rd_vld_in;
         period_ff    <= period_in;
         compare_ff   <= compare_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff       <= phase_in;
      status_ff      <= status_in;
      scan_idx_ff    <= scan_idx_in;
      word_idx_ff    <= word_idx_in;
      p_ok_ff        <= p_ok_in;
      d_ok_ff        <= d_ok_in;
      first_q_ff     <= first_q_in;
      neg_ff         <= neg_in;
      acc_ff         <= acc_in;
      num_ff         <= num_in;
      prod_ff        <= prod_in;
      scaled_ff      <= scaled_in;
      sat_ff         <= sat_in;
      byte_ff        <= byte_in;
      rsp_echo_ff    <= rsp_echo_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_period_ff  <= rsp_period_in;
      rsp_compare_ff <= rsp_compare_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_compare_ff, rsp_period_ff, rsp_echo_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_done_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      line_len_ff <= LW'(LINE_LEN))
      else $error("line length beyond buffer");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> state_ff == spcc_pkg::ST_SCAN)
      else $error("line read pending outside scan");

   a_cr_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tdata == spcc_pkg::CHAR_CR) |=> state_ff == spcc_pkg::ST_SCAN)
      else $error("carriage return did not start scan");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> rsp_last_ff)
      else $error("line result not marked last");

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_done_ff) |-> rsp_status_ff == spcc_pkg::STAT_NONE)
      else $error("status on an echo beat");

endmodule

FILE: verif/serial_pwm_command_console_unit_tb.sv
module serial_pwm_command_console_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_LEN    = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 160;
   localparam int HOLD_AT     = 60;
   localparam int PAUSE_AT    = 100;
   localparam int CALM_FROM   = 135;

   typedef struct {
      logic [7:0]  echo;
      logic        done;
      logic [2:0]  status;
      logic [15:0] period;
      logic [15:0] compare;
      logic        last;
   } console_beat_type;

   class console_scoreboard;
      logic [7:0]       line_text [LINE_LEN];
      int               line_len;
      logic [15:0]      period_now;
      logic [15:0]      compare_now;
      console_beat_type beats_due [$];
      int               errors;

      function new();
         line_len    = 0;
         period_now  = spcc_pkg::PERIOD_RESET;
         compare_now = spcc_pkg::COMPARE_RESET;
         errors      = 0;
      endfunction

      function int pending();
         return beats_due.size();
      endfunction

      function void push_beat(logic [7:0] echo, logic done, spcc_pkg::status_type st,
                              logic last);
         console_beat_type b;
         b.echo    = echo;
         b.done    = done;
         b.status  = st;
         b.period  = period_now;
         b.compare = compare_now;
         b.last    = last;
         beats_due.push_back(b);
      endfunction

      function bit word_is(int len, string w);
         if (len != w.len())
            return 0;
         for (int i = 0; i < len; i++)
            if (line_text[i] != w[i])
               return 0;
         return 1;
      endfunction

      // atoi style with saturation to 0..65535
      function logic [15:0] read_number(int pos);
         bit          neg;
         int unsigned acc;
         int          p;
         neg = 0;
         acc = 0;
         p   = pos;
         while (p < line_len && line_text[p] == spcc_pkg::CHAR_SPACE)
            p++;
         if (p < line_len && (line_text[p] == spcc_pkg::CHAR_PLUS ||
                              line_text[p] == spcc_pkg::CHAR_MINUS)) begin
            neg = (line_text[p] == spcc_pkg::CHAR_MINUS);
            p++;
         end
         while (p < line_len && line_text[p] >= spcc_pkg::CHAR_ZERO &&
                line_text[p] <= spcc_pkg::CHAR_NINE) begin
            acc = acc * 10 + (line_text[p] - spcc_pkg::CHAR_ZERO);
            if (acc > 65535)
               acc = 65536;
            p++;
         end
         if (neg)
            return 16'd0;
         return (acc > 65535) ? 16'hffff : acc[15:0];
      endfunction

      function spcc_pkg::status_type parse_line();
         int              sp;
         longint unsigned scaled;
         if (line_len == 1 && line_text[0] == spcc_pkg::CHAR_QUERY)
            return spcc_pkg::STAT_HELP;
         sp = 0;
         while (sp < line_len && line_text[sp] != spcc_pkg::CHAR_SPACE)
            sp++;
         if (sp >= line_len)
            return spcc_pkg::STAT_NONE;
         if (word_is(sp, "period")) begin
            period_now = read_number(sp + 1);
            return spcc_pkg::STAT_PERIOD;
         end
         if (word_is(sp, "duty")) begin
            scaled = read_number(sp + 1);
            scaled = scaled * period_now / 100;
            compare_now = (scaled > 65535) ? 16'hffff : scaled[15:0];
            return spcc_pkg::STAT_DUTY;
         end
         return spcc_pkg::STAT_INVALID;
      endfunction

      // returns the number of beats this byte causes
      function int note_input(logic [7:0] rx);
         spcc_pkg::status_type st;
         if (rx == spcc_pkg::CHAR_CR) begin
            st = parse_line();
            line_len = 0;
            push_beat(spcc_pkg::CHAR_LF, 1'b1, st, 1'b1);
            return 1;
         end
         if (rx == spcc_pkg::CHAR_BS) begin
            if (line_len == 0)
               return 0;
            line_len--;
            push_beat(spcc_pkg::CHAR_BS, 1'b0, spcc_pkg::STAT_NONE, 1'b0);
            push_beat(spcc_pkg::CHAR_SPACE, 1'b0, spcc_pkg::STAT_NONE, 1'b0);
            push_beat(spcc_pkg::CHAR_BS, 1'b0, spcc_pkg::STAT_NONE, 1'b1);
            return 3;
         end
         if (rx >= spcc_pkg::CHAR_SPACE && line_len < LINE_LEN) begin
            line_text[line_len] = rx;
            line_len++;
            push_beat(rx, 1'b0, spcc_pkg::STAT_NONE, 1'b1);
            return 1;
         end
         return 0;
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [39:0] data, logic [3:0] user, logic last);
         console_beat_type b;
         if (beats_due.size() == 0) begin
            $display({"%0t: unexpected beat, expected none, actual echo %0d done %0d",
                      " status %0d period %0d compare %0d last %0d"},
                     $time, data[7:0], user[0], user[3:1], data[23:8], data[39:24], last);
            errors++;
            return;
         end
         b = beats_due.pop_front();
         compare_field("echo_byte", b.echo, data[7:0]);
         compare_field("period_value", b.period, data[23:8]);
         compare_field("compare_value", b.compare, data[39:24]);
         compare_field("line_done", b.done, user[0]);
         compare_field("status", b.status, user[3:1]);
         compare_field("last", b.last, last);
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   console_scoreboard sb;
   int cycles       = 0;
   int worked_items = 0;
   int stall_left   = 0;
   bit hold_done    = 0;

   serial_pwm_command_console_unit #(
      .LINE_LEN(LINE_LEN)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("serial_pwm_command_console_unit_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // receiver side: random stall bursts, one long hold-off, none near the end
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (!hold_done && worked_items >= HOLD_AT) begin
         hold_done = 1;
         stall_left = 399;
         rsp_tready <= 1'b0;
      end else if (worked_items < CALM_FROM && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // entered and left at a falling edge
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (sb.note_input(rx) > 0)
         worked_items++;
      @(negedge clock);
      if (worked_items < CALM_FROM && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // messy adds typo-and-erase pairs and stray control bytes
   task automatic send_text(input string s, input bit messy);
      logic [7:0] junk;
      for (int i = 0; i < s.len(); i++) begin
         if (messy && $urandom_range(0, 11) == 0) begin
            send_byte(8'($urandom_range(33, 126)));
            send_byte(spcc_pkg::CHAR_BS);
         end else if (messy && $urandom_range(0, 19) == 0) begin
            junk = 8'($urandom_range(0, 31));
            if (junk == spcc_pkg::CHAR_BS || junk == spcc_pkg::CHAR_CR)
               junk++;
            send_byte(junk);
         end
         send_byte(s[i]);
      end
   endtask

   function automatic string rand_number();
      string s;
      s = "";
      repeat ($urandom_range(0, 2)) s = {s, " "};
      case ($urandom_range(0, 5))
         0:       s = {s, "-"};
         1:       s = {s, "+"};
         default: ;
      endcase
      case ($urandom_range(0, 7))
         0:       s = {s, $sformatf("%0d", $urandom_range(65530, 65540))};
         1:       s = {s, $sformatf("%0d", $urandom)};
         2:       ;
         3:       s = {s, "0"};
         4:       s = {s, $sformatf("%0d", $urandom_range(0, 120))};
         default: s = {s, $sformatf("%0d", $urandom_range(0, 1000))};
      endcase
      if ($urandom_range(0, 4) == 0)
         s = {s, "x7"};
      return s;
   endfunction

   function automatic string rand_word();
      string s;
      s = "";
      repeat ($urandom_range(1, 7)) s = {s, $sformatf("%c", $urandom_range(97, 122))};
      return s;
   endfunction

   task automatic send_random_line();
      string w;
      case ($urandom_range(0, 11))
         0, 1, 2: send_text({"period ", rand_number()}, 1);
         3, 4, 5: send_text({"duty ", rand_number()}, 1);
         6:       send_text("?", 1);
         7:       send_text({rand_word(), " ", rand_number()}, 1);
         8: begin
            case ($urandom_range(0, 5))
               0:       w = "period";
               1:       w = "duty";
               2:       w = "??";
               3:       w = "perio 5";
               4:       w = "Duty 5";
               default: w = rand_word();
            endcase
            send_text(w, 1);
         end
         9:       send_text({" duty", rand_number()}, 1);
         10:      repeat ($urandom_range(30, 40)) send_byte(8'($urandom_range(32, 255)));
         default: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      endcase
      send_byte(spcc_pkg::CHAR_CR);
   endtask

   initial begin
      bit pause_done;
      sb = new();
      pause_done = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // backspace on empty line, ignored controls, high bytes, empty line
      send_byte(spcc_pkg::CHAR_BS);
      send_byte(8'd0);
      send_byte(8'd31);
      send_byte(8'd255);
      send_byte(8'd127);
      send_byte(spcc_pkg::CHAR_BS);
      send_byte(spcc_pkg::CHAR_BS);
      send_byte(spcc_pkg::CHAR_CR);
      send_text("?", 0);
      send_byte(spcc_pkg::CHAR_CR);
      send_text(" x", 0);
      send_byte(spcc_pkg::CHAR_CR);
      send_text("duty 9", 0);
      send_byte(spcc_pkg::CHAR_CR);
      send_byte(spcc_pkg::CHAR_CR);
      wait_drained();

      while (worked_items < ITEM_TARGET) begin
         if (!pause_done && worked_items >= PAUSE_AT) begin
            pause_done = 1;
            wait_drained();
         end
         send_random_line();
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("serial_pwm_command_console_unit_tb: done, clean");
      else
         $display("serial_pwm_command_console_unit_tb: done, errors");
      $finish;
   end

endmodule
